/* rtl/stsg_pkg.sv */
// shared constants, types and sine table for the sine tone sample generator
package stsg_pkg;

  localparam int PhaseBits     = 32;
  localparam int TableEntries  = 1024;
  localparam int TableBits     = $clog2(TableEntries);
  localparam int QuarterBits   = TableBits - 2;
  localparam int QuarterEntries = 1 << QuarterBits;
  localparam int MagBits       = 15;
  localparam int SampleBits    = 16;
  localparam int FrameBits     = 32;
  localparam int ScaleBits     = 17;
  localparam int ScaleShift    = 17;

  // three quarters of full scale, kept as 3 * full scale with the divide by 4 in the shift
  localparam logic [ScaleBits-1:0] Scale8  = ScaleBits'(3 * 127);
  localparam logic [ScaleBits-1:0] Scale16 = ScaleBits'(3 * 32767);

  localparam longint OneQ30 = longint'(1) << 30;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_WIDTH_MODE   = 2'd1,
    REG_STEREO_MODE  = 2'd2,
    REG_CHANNEL_SEL  = 2'd3
  } cfg_reg_e;

  localparam logic [PhaseBits-1:0] PhaseStepReset = PhaseBits'(63499290);

  typedef logic [MagBits-1:0] quarter_table_t [QuarterEntries];

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / OneQ30;
  endfunction

  // magnitude of the q15 sine for quarter-wave position j of QuarterEntries
  function automatic logic [MagBits-1:0] quarter_mag(int j);
    longint x;
    longint x2;
    longint p;
    longint r;
    x  = longint'(j) << (30 - QuarterBits);
    x2 = mul_q30(x, x);
    p  = 172272;
    p  = -5026995 + mul_q30(p, x2);
    p  = 85569306 + mul_q30(p, x2);
    p  = -693598668 + mul_q30(p, x2);
    p  = 1686629713 + mul_q30(p, x2);
    p  = mul_q30(p, x);
    if (p < 0) begin
      p = 0;
    end
    r = (p + (longint'(1) << 14)) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return MagBits'(r);
  endfunction

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t t;
    for (int j = 0; j < QuarterEntries; j++) begin
      t[j] = quarter_mag(j);
    end
    return t;
  endfunction

  localparam quarter_table_t QuarterTable = build_quarter_table();
  // value at a quarter turn, just past the end of the table
  localparam logic [MagBits-1:0] MagPeak = quarter_mag(QuarterEntries);

endpackage

/* rtl/sine_tone_sample_generator.sv */
// sine tone sample generator: phase accumulator, quarter-wave table, scaling and frame packing
// registers from input accept to result valid: table stage, then scale and pack stage
// throughput: one item per cycle while the output is not stalled, set by the phase add and table read
// the result register frees in the same cycle it is taken, so stalls only hold the pipeline
// reset: phase accumulator 0, phase_step 63499290, 8-bit mono, channel select left, no items held
module sine_tone_sample_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] sample_value, [47:16] frame_word
);

  logic [stsg_pkg::PhaseBits-1:0] phase_step_q;
  logic                           width_mode_q;
  logic                           stereo_mode_q;
  logic [1:0]                     channel_sel_q;

  logic [stsg_pkg::PhaseBits-1:0] acc_q, acc_d;
  logic                           tab_valid_q;
  logic [stsg_pkg::MagBits-1:0]   mag_q, mag_d;
  logic                           neg_q, neg_d;
  logic                           out_valid_q;
  logic [stsg_pkg::SampleBits-1:0] sample_q, sample_d;
  logic [stsg_pkg::FrameBits-1:0]  frame_q, frame_d;

  logic                           in_fire;
  logic                           out_load;
  logic [stsg_pkg::PhaseBits-1:0] phase;
  logic [stsg_pkg::TableBits-1:0] tab_idx;
  logic [stsg_pkg::QuarterBits-1:0] frac;
  logic [stsg_pkg::QuarterBits-1:0] mirror;
  logic [stsg_pkg::ScaleBits-1:0] scale;
  logic [stsg_pkg::MagBits+stsg_pkg::ScaleBits-1:0] product;
  logic [stsg_pkg::MagBits-1:0]   scaled;
  logic [7:0]                     byte_val;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= stsg_pkg::PhaseStepReset;
      width_mode_q  <= 1'b0;
      stereo_mode_q <= 1'b0;
      channel_sel_q <= 2'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stsg_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data_i[stsg_pkg::PhaseBits-1:0];
        stsg_pkg::REG_WIDTH_MODE:  width_mode_q  <= cfg_data_i[0];
        stsg_pkg::REG_STEREO_MODE: stereo_mode_q <= cfg_data_i[0];
        stsg_pkg::REG_CHANNEL_SEL: channel_sel_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the result register is free or being taken
  assign out_load      = tab_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !tab_valid_q || out_load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign phase   = s_axis_tdata[0] ? '0 : acc_q;
  assign acc_d   = phase + phase_step_q;
  assign tab_idx = phase[stsg_pkg::PhaseBits-1 -: stsg_pkg::TableBits];
  assign frac    = tab_idx[stsg_pkg::QuarterBits-1:0];
  assign mirror  = '0 - frac;

  // quarter-wave lookup, mirrored on odd quadrants, negated on the upper half of the phase range
  always_comb begin
    neg_d = tab_idx[stsg_pkg::TableBits-1];
    if (!tab_idx[stsg_pkg::TableBits-2]) begin
      mag_d = stsg_pkg::QuarterTable[frac];
    end else if (frac == '0) begin
      mag_d = stsg_pkg::MagPeak;
    end else begin
      mag_d = stsg_pkg::QuarterTable[mirror];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tab_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        acc_q <= acc_d;
      end
      if (s_axis_tready) begin
        tab_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // scale on the magnitude so the shift truncates toward zero
  assign scale   = width_mode_q ? stsg_pkg::Scale16 : stsg_pkg::Scale8;
  assign product = {{stsg_pkg::ScaleBits{1'b0}}, mag_q} * {{stsg_pkg::MagBits{1'b0}}, scale};
  assign scaled  = product[stsg_pkg::ScaleShift +: stsg_pkg::MagBits];

  always_comb begin
    sample_d = neg_q ? (16'd0 - {1'b0, scaled}) : {1'b0, scaled};
    byte_val = sample_d[7:0];
    if (width_mode_q) begin
      if (!stereo_mode_q) begin
        frame_d = {16'd0, sample_d};
      end else if (channel_sel_q[1]) begin
        frame_d = {sample_d, sample_d};
      end else if (channel_sel_q[0]) begin
        frame_d = {sample_d, 16'd0};
      end else begin
        frame_d = {16'd0, sample_d};
      end
    end else begin
      if (!stereo_mode_q) begin
        frame_d = {24'd0, byte_val};
      end else if (channel_sel_q[1]) begin
        frame_d = {16'd0, byte_val, byte_val};
      end else if (channel_sel_q[0]) begin
        frame_d = {16'd0, byte_val, 8'd0};
      end else begin
        frame_d = {24'd0, byte_val};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= tab_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= sample_d;
      frame_q  <= frame_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {frame_q, sample_q};

endmodule
